// ===== src/hte_pkg.sv =====
// Shared types and constants for the table-driven variable-length code packer.
// No dependencies; imported by every module under src.
`timescale 1ns / 1ps

package hte_pkg;

    // Field widths that are fixed by the item formats
    localparam int SYMBOL_FIELD_BITS = 8;
    localparam int CODE_FIELD_BITS   = 16;
    localparam int LEN_FIELD_BITS    = 5;
    localparam int TOTAL_FIELD_BITS  = 16;
    localparam int BYTE_BITS         = 8;

    // Defaults for the top-level parameters
    localparam int SYMBOL_BITS_DEF   = 8;
    localparam int MAX_CODE_BITS_DEF = 16;

    // Depth of the queue between the lookup front end and the packer
    localparam int QUEUE_DEPTH       = 4;

    // Item opcodes (code 3 is ignored)
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ENCODE = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;

    typedef struct packed {
        logic [1:0]                   mode;
        logic [SYMBOL_FIELD_BITS-1:0] symbol;
        logic [CODE_FIELD_BITS-1:0]   code_word;
        logic [LEN_FIELD_BITS-1:0]    code_length;
    } hte_in_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0]        out_byte;
        logic                        is_data;
        logic [TOTAL_FIELD_BITS-1:0] total_bits;
        logic                        last;
    } hte_out_t;

    // Fill level the queue reports to the front end
    typedef struct packed {
        logic [$clog2(QUEUE_DEPTH+1)-1:0] count;
    } hte_qstat_t;

endpackage

// ===== src/huffman_table_encoder_top.sv =====
// Top level of the table-driven variable-length code packer.
// Depends on hte_pkg, hte_front, hte_queue and hte_back.
`timescale 1ns / 1ps

// Load transactions write one code table entry; encode transactions append the
// entry's code MSB first and emit each completed byte; a finish transaction pads
// and emits any partial byte, then emits the 16-bit block bit count marked last.
// Input is taken every cycle while the four-entry queue has room; the table lookup
// is registered. The byte-wide result port emits one result per cycle while m_ready
// is high, and the next item is taken only as the results of the last one drain.
// Encoding a symbol never loaded is not allowed.
module huffman_table_encoder_top #(
    parameter int SYMBOL_BITS   = hte_pkg::SYMBOL_BITS_DEF,
    parameter int MAX_CODE_BITS = hte_pkg::MAX_CODE_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hte_pkg::hte_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output hte_pkg::hte_out_t m_data
);
    import hte_pkg::*;

    localparam int CODE_W = (MAX_CODE_BITS < CODE_FIELD_BITS) ? MAX_CODE_BITS : CODE_FIELD_BITS;
    localparam int LEN_W  = $clog2(CODE_W + 1);
    localparam int ITEM_W = 1 + CODE_W + LEN_W;

    hte_qstat_t        q_stat;
    logic              q_push, q_pop, q_valid;
    logic [ITEM_W-1:0] push_item, pop_item;

    hte_front #(
        .SYMBOL_BITS   (SYMBOL_BITS),
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .CODE_W        (CODE_W),
        .LEN_W         (LEN_W),
        .ITEM_W        (ITEM_W)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_item  (push_item)
    );

    hte_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (pop_item),
        .stat      (q_stat)
    );

    hte_back #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .CODE_W        (CODE_W),
        .LEN_W         (LEN_W),
        .ITEM_W        (ITEM_W)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_item  (pop_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== src/hte_front.sv =====
// Front end: accepts input transactions, holds the code table, looks up encode symbols.
// Depends on hte_pkg; feeds hte_queue.
`timescale 1ns / 1ps

module hte_front #(
    parameter int SYMBOL_BITS   = hte_pkg::SYMBOL_BITS_DEF,
    parameter int MAX_CODE_BITS = hte_pkg::MAX_CODE_BITS_DEF,
    parameter int CODE_W        = (MAX_CODE_BITS < hte_pkg::CODE_FIELD_BITS) ?
                                  MAX_CODE_BITS : hte_pkg::CODE_FIELD_BITS,
    parameter int LEN_W         = $clog2(CODE_W + 1),
    parameter int ITEM_W        = 1 + CODE_W + LEN_W
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  hte_pkg::hte_in_t       s_data,
    input  hte_pkg::hte_qstat_t    q_stat,
    output logic                   q_push,
    output logic [ITEM_W-1:0]      q_item
);
    import hte_pkg::*;

    localparam int DEPTH   = 1 << SYMBOL_BITS;
    localparam int ENTRY_W = CODE_W + LEN_W;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

    logic [ENTRY_W-1:0]     table_mem [DEPTH];
    logic [ENTRY_W-1:0]     rd_entry_reg;
    logic                   s1_valid_reg;
    logic                   s1_finish_reg;

    logic                   accept;
    logic [SYMBOL_BITS-1:0] idx;
    logic [LEN_FIELD_BITS-1:0]  len_sat;
    logic [CODE_FIELD_BITS:0]   len_mask;
    logic [CODE_FIELD_BITS-1:0] code_masked;
    logic [CNT_W:0]         in_flight;

    // Credit check: queued entries plus the one in the lookup stage must leave room
    assign in_flight = (CNT_W+1)'(q_stat.count) + (CNT_W+1)'(s1_valid_reg);
    assign s_ready   = in_flight < (CNT_W+1)'(QUEUE_DEPTH);
    assign accept    = s_valid && s_ready;
    assign idx       = SYMBOL_BITS'(s_data.symbol);

    // Saturate the length and drop stray code bits above it
    always_comb begin
        if (s_data.code_length > LEN_FIELD_BITS'(CODE_W)) begin
            len_sat = LEN_FIELD_BITS'(CODE_W);
        end else begin
            len_sat = s_data.code_length;
        end
        len_mask    = ((CODE_FIELD_BITS+1)'(1) << len_sat) - (CODE_FIELD_BITS+1)'(1);
        code_masked = s_data.code_word & len_mask[CODE_FIELD_BITS-1:0];
    end

    // Code table: one write port for loads, one registered read port for lookups
    always_ff @(posedge aclk) begin
        if (accept && s_data.mode == MODE_LOAD) begin
            table_mem[idx] <= {CODE_W'(code_masked), LEN_W'(len_sat)};
        end
        if (accept) begin
            rd_entry_reg <= table_mem[idx];
        end
    end

    // Lookup stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s1_finish_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= accept &&
                             (s_data.mode == MODE_ENCODE || s_data.mode == MODE_FINISH);
            s1_finish_reg <= s_data.mode == MODE_FINISH;
        end
    end

    assign q_push = s1_valid_reg;
    assign q_item = {s1_finish_reg, rd_entry_reg};

endmodule

// ===== src/hte_queue.sv =====
// Small FIFO between the lookup front end and the bit packer.
// Depends on hte_pkg.
`timescale 1ns / 1ps

module hte_queue #(
    parameter int WIDTH = 22,
    parameter int DEPTH = hte_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  logic [WIDTH-1:0]    push_item,
    input  logic                pop,
    output logic                pop_valid,
    output logic [WIDTH-1:0]    pop_item,
    output hte_pkg::hte_qstat_t stat
);
    import hte_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign pop_valid = count_reg != '0;
    assign pop_item  = slot_reg[rd_ptr_reg];
    assign stat.count = CNT_W'(count_reg);

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/hte_back.sv =====
// Back end: appends codes to the bit accumulator and drives the result channel.
// Depends on hte_pkg; fed by hte_queue.
`timescale 1ns / 1ps

module hte_back #(
    parameter int MAX_CODE_BITS = hte_pkg::MAX_CODE_BITS_DEF,
    parameter int CODE_W        = (MAX_CODE_BITS < hte_pkg::CODE_FIELD_BITS) ?
                                  MAX_CODE_BITS : hte_pkg::CODE_FIELD_BITS,
    parameter int LEN_W         = $clog2(CODE_W + 1),
    parameter int ITEM_W        = 1 + CODE_W + LEN_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  logic [ITEM_W-1:0]   q_item,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output hte_pkg::hte_out_t   m_data
);
    import hte_pkg::*;

    localparam int PEND_W = BYTE_BITS - 1;
    localparam int PCNT_W = $clog2(BYTE_BITS);
    localparam int ACC_W  = PEND_W + CODE_W;
    localparam int CNT_W  = $clog2(ACC_W + 1);

    // Accumulator state
    logic [PEND_W-1:0]           pend_bits_reg, pend_bits_next;
    logic [PCNT_W-1:0]           pend_cnt_reg, pend_cnt_next;
    logic [TOTAL_FIELD_BITS-1:0] bit_total_reg, bit_total_next;

    // Two-deep result buffer
    hte_out_t res_a_reg, res_b_reg;
    logic [1:0] res_cnt_reg;
    hte_out_t new_a, new_b;
    logic [1:0] new_cnt;

    logic              is_finish;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [ACC_W-1:0]  acc;
    logic [CNT_W-1:0]  cnt;
    logic [ACC_W-1:0]  hi_byte, lo_byte;
    logic [BYTE_BITS-1:0] pad_byte;
    logic [BYTE_BITS-1:0] rem_mask;
    logic              take;

    assign {is_finish, code, len} = q_item;

    assign m_valid = res_cnt_reg != 2'd0;
    assign m_data  = res_a_reg;
    assign take    = m_valid && m_ready;
    // Pop only when the result buffer drains this cycle
    assign q_pop   = q_valid && (res_cnt_reg == 2'd0 || (res_cnt_reg == 2'd1 && m_ready));

    // Append the code and split off whole bytes
    always_comb begin
        acc      = (ACC_W'(pend_bits_reg) << len) | ACC_W'(code);
        cnt      = CNT_W'(pend_cnt_reg) + CNT_W'(len);
        hi_byte  = acc >> (cnt - CNT_W'(BYTE_BITS));
        lo_byte  = acc >> (cnt - CNT_W'(2 * BYTE_BITS));
        pad_byte = BYTE_BITS'({1'b0, pend_bits_reg}) << (BYTE_BITS'(BYTE_BITS) -
                   BYTE_BITS'(pend_cnt_reg));
        rem_mask = (BYTE_BITS'(1) << cnt[PCNT_W-1:0]) - BYTE_BITS'(1);

        new_a = '0;
        new_b = '0;
        new_a.is_data = 1'b1;
        new_b.is_data = 1'b1;

        if (is_finish) begin
            pend_bits_next = '0;
            pend_cnt_next  = '0;
            bit_total_next = '0;
            if (pend_cnt_reg != '0) begin
                new_a.out_byte   = pad_byte;
                new_b.is_data    = 1'b0;
                new_b.total_bits = bit_total_reg;
                new_b.last       = 1'b1;
                new_cnt          = 2'd2;
            end else begin
                new_a.is_data    = 1'b0;
                new_a.total_bits = bit_total_reg;
                new_a.last       = 1'b1;
                new_cnt          = 2'd1;
            end
        end else begin
            pend_bits_next = acc[PEND_W-1:0] & rem_mask[PEND_W-1:0];
            pend_cnt_next  = cnt[PCNT_W-1:0];
            bit_total_next = bit_total_reg + TOTAL_FIELD_BITS'(len);
            if (cnt >= CNT_W'(2 * BYTE_BITS)) begin
                new_a.out_byte = hi_byte[BYTE_BITS-1:0];
                new_b.out_byte = lo_byte[BYTE_BITS-1:0];
                new_cnt        = 2'd2;
            end else if (cnt >= CNT_W'(BYTE_BITS)) begin
                new_a.out_byte = hi_byte[BYTE_BITS-1:0];
                new_cnt        = 2'd1;
            end else begin
                new_cnt        = 2'd0;
            end
        end
    end

    // Accumulator registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            bit_total_reg <= '0;
        end else if (q_pop) begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            bit_total_reg <= bit_total_next;
        end
    end

    // Result buffer: load on pop, shift on each output transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_cnt_reg <= 2'd0;
        end else if (q_pop) begin
            res_cnt_reg <= new_cnt;
        end else if (take) begin
            res_cnt_reg <= res_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            res_a_reg <= new_a;
            res_b_reg <= new_b;
        end else if (take) begin
            res_a_reg <= res_b_reg;
        end
    end

endmodule
